### sv/stl_pkg.sv
package stl_pkg;

  // Byte classes found by the front end
  typedef enum logic [2:0] {
    CL_SKIP,
    CL_SPACE,
    CL_ALPHA,
    CL_DIGIT,
    CL_QUOTE,
    CL_OP,
    CL_SYM
  } cls_e;

  // One classified source byte
  typedef struct packed {
    logic [7:0] c;
    logic       last;
    cls_e       cls;
    logic [2:0] op;
    logic [5:0] sk;
  } item_t;

  localparam logic [5:0] K_UNKNOWN = 6'd0;
  localparam logic [5:0] K_PUNCT0  = 6'd19;
  localparam logic [5:0] K_BOOLEAN = 6'd39;
  localparam logic [5:0] K_IDENT   = 6'd40;
  localparam logic [5:0] K_NUMBER  = 6'd41;
  localparam logic [5:0] K_STRING  = 6'd42;

  localparam logic [7:0] OP_CHAR [8] = '{8'h3D, 8'h21, 8'h3E, 8'h3C,
                                         8'h2B, 8'h2D, 8'h2A, 8'h2F};
  localparam logic [5:0] OP_SINGLE [8] = '{6'd1, 6'd3, 6'd5, 6'd7,
                                           6'd9, 6'd12, 6'd15, 6'd17};
  localparam logic [5:0] OP_EQ [8] = '{6'd2, 6'd4, 6'd6, 6'd8,
                                       6'd10, 6'd13, 6'd16, 6'd18};
  localparam logic [5:0] OP_DOUBLE [8] = '{6'd0, 6'd0, 6'd0, 6'd0,
                                           6'd11, 6'd14, 6'd0, 6'd0};

  localparam logic [7:0] PUNCT_CHAR [11] = '{8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                                             8'h3B, 8'h27, 8'h22, 8'h2C, 8'h2E};

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Keyword table, padded with zero bytes
  localparam int KW_NUM = 11;
  localparam int KW_MAXLEN = 5;
  localparam logic [7:0] KW_CHAR [KW_NUM][KW_MAXLEN] = '{
    '{"a", "n", "d", 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"f", "u", "n", 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"n", "i", "l", 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"}
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd4, 3'd3, 3'd3, 3'd2, 3'd3,
                                             3'd2, 3'd3, 3'd5, 3'd4, 3'd5};
  localparam logic [5:0] KW_KIND [KW_NUM] = '{6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
                                              6'd36, 6'd37, 6'd38, 6'd39, 6'd39};

endpackage

### sv/stl_front.sv
module stl_front import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       end_of_source_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);

  item_t      cls_item;
  item_t      q_mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  // Classify the incoming byte
  always_comb begin
    cls_item.c    = source_byte_i;
    cls_item.last = end_of_source_i;
    cls_item.cls  = CL_SKIP;
    cls_item.op   = 3'd0;
    cls_item.sk   = K_UNKNOWN;
    if (source_byte_i == 8'h20 || source_byte_i == 8'h09 || source_byte_i == 8'h0A) begin
      cls_item.cls = CL_SPACE;
    end else if ((source_byte_i >= "a" && source_byte_i <= "z") ||
                 (source_byte_i >= "A" && source_byte_i <= "Z")) begin
      cls_item.cls = CL_ALPHA;
    end else if (source_byte_i >= "0" && source_byte_i <= "9") begin
      cls_item.cls = CL_DIGIT;
    end else if (source_byte_i == CH_SQUOTE || source_byte_i == CH_DQUOTE) begin
      cls_item.cls = CL_QUOTE;
    end else if ((source_byte_i >= 8'd33 && source_byte_i <= 8'd47) ||
                 (source_byte_i >= 8'd58 && source_byte_i <= 8'd64) ||
                 (source_byte_i >= 8'd91 && source_byte_i <= 8'd96) ||
                 (source_byte_i >= 8'd123 && source_byte_i <= 8'd126)) begin
      cls_item.cls = CL_SYM;
      for (int i = 0; i < 11; i++) begin
        if (source_byte_i == PUNCT_CHAR[i]) cls_item.sk = K_PUNCT0 + 6'(i);
      end
      for (int i = 0; i < 8; i++) begin
        if (source_byte_i == OP_CHAR[i]) begin
          cls_item.cls = CL_OP;
          cls_item.op  = 3'(i);
        end
      end
    end
  end

  // Two-entry queue toward the back end
  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = q_mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= cls_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

### sv/stl_back.sv
module stl_back import stl_pkg::*; #(
  parameter int TEXT_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] token_kind_o,
  output logic [7:0] text_byte_o,
  output logic       has_text_o,
  output logic       token_end_o,
  output logic       text_truncated_o,
  output logic       run_end_o
);

  localparam int LW = $clog2(TEXT_DEPTH + 1);
  localparam int AW = $clog2(TEXT_DEPTH);

  typedef enum logic [2:0] {M_IDLE, M_WORD, M_NUM, M_STR, M_OP} mode_e;
  typedef enum logic [2:0] {S_WAIT, S_EXEC, S_PRE, S_TEXT, S_ONE, S_START, S_LAST, S_FIN}
    state_e;

  state_e         st_q;
  mode_e          mode_q, start_mode;
  item_t          it_q;
  logic [LW-1:0]  len_q, idx_q, idx_nx;
  logic           ovf_q, dq_q;
  logic [2:0]     pop_q;
  logic [KW_NUM-1:0] kwm_q, kwm_app, kwm_new;
  logic [5:0]     g_kind_q;
  logic           g_trunc_q, g_more_q, g_start_q;
  logic [7:0]     mem [TEXT_DEPTH];
  logic [7:0]     rd_q;

  logic           out_ready, room, txt_end;
  logic           kw_hit;
  logic [5:0]     kw_kind, grp_kind;
  logic           grp_text, start_more, cont, close_hit;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data;

  assign out_ready = !out_valid_o || !out_stall_i;
  assign room      = (len_q < LW'(TEXT_DEPTH));
  assign idx_nx    = idx_q + LW'(1);
  assign txt_end   = (idx_nx == len_q);
  assign q_pop_o   = (st_q == S_WAIT || st_q == S_FIN) && q_valid_i;

  // Keyword match, tracked per keyword as bytes are appended
  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      kwm_new[k] = (KW_CHAR[k][0] == it_q.c);
      kwm_app[k] = kwm_q[k] &&
                   ((len_q >= LW'(KW_MAXLEN)) || (KW_CHAR[k][3'(len_q)] == it_q.c));
      if (kwm_q[k] && len_q == LW'(KW_LEN[k]) && !ovf_q) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  // Token that the current mode flushes
  always_comb begin
    grp_text = 1'b1;
    grp_kind = K_UNKNOWN;
    case (mode_q)
      M_WORD: begin
        if (kw_hit && kw_kind != K_BOOLEAN) begin
          grp_text = 1'b0;
          grp_kind = kw_kind;
        end else begin
          grp_kind = kw_hit ? K_BOOLEAN : K_IDENT;
        end
      end
      M_NUM: grp_kind = K_NUMBER;
      M_STR: grp_kind = K_STRING;
      M_OP: begin
        grp_text = 1'b0;
        grp_kind = OP_SINGLE[pop_q];
      end
      default: grp_text = 1'b0;
    endcase
  end

  // What the current byte does once the old token is out
  always_comb begin
    case (it_q.cls)
      CL_ALPHA: start_mode = M_WORD;
      CL_DIGIT: start_mode = M_NUM;
      CL_QUOTE: start_mode = M_STR;
      CL_OP:    start_mode = M_OP;
      default:  start_mode = M_IDLE;
    endcase
    start_more = (it_q.cls == CL_SYM) || (it_q.last && start_mode != M_IDLE);
    close_hit  = (it_q.cls == CL_QUOTE) && ((it_q.c == CH_DQUOTE) == dq_q);
    case (mode_q)
      M_WORD:  cont = (it_q.cls == CL_ALPHA) || (it_q.cls == CL_DIGIT) ||
                      (it_q.c == CH_UNDER);
      M_NUM:   cont = (it_q.cls == CL_DIGIT) || (it_q.c == CH_DOT);
      M_STR:   cont = !close_hit;
      default: cont = 1'b0;
    endcase
  end

  // Text memory ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = len_q[AW-1:0];
    wr_data = it_q.c;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (st_q == S_EXEC && cont && room) wr_en = 1'b1;
    if (st_q == S_START && (it_q.cls == CL_ALPHA || it_q.cls == CL_DIGIT)) begin
      wr_en   = 1'b1;
      wr_addr = '0;
    end
    if (st_q == S_PRE) rd_en = 1'b1;
    if (st_q == S_TEXT && out_ready && !txt_end) begin
      rd_en   = 1'b1;
      rd_addr = idx_nx[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Sequencer with lexer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_WAIT;
      mode_q      <= M_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      dq_q        <= 1'b0;
      pop_q       <= 3'd0;
      kwm_q       <= '0;
      out_valid_o <= 1'b0;
      it_q        <= '0;
      idx_q       <= '0;
      g_kind_q    <= K_UNKNOWN;
      g_trunc_q   <= 1'b0;
      g_more_q    <= 1'b0;
      g_start_q   <= 1'b0;
      token_kind_o     <= K_UNKNOWN;
      text_byte_o      <= 8'd0;
      has_text_o       <= 1'b0;
      token_end_o      <= 1'b0;
      text_truncated_o <= 1'b0;
      run_end_o        <= 1'b0;
    end else begin
      if (!out_stall_i) out_valid_o <= 1'b0;
      case (st_q)
        S_WAIT: begin
          if (q_valid_i) begin
            it_q <= q_item_i;
            st_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (mode_q)
            M_WORD, M_NUM, M_STR: begin
              if (cont) begin
                if (room) len_q <= len_q + LW'(1);
                else ovf_q <= 1'b1;
                kwm_q <= kwm_app;
                st_q  <= it_q.last ? S_LAST : S_FIN;
              end else begin
                g_kind_q  <= grp_kind;
                g_trunc_q <= grp_text ? ovf_q : 1'b0;
                g_more_q  <= (mode_q == M_STR) ? 1'b0 : start_more;
                g_start_q <= (mode_q != M_STR);
                mode_q    <= M_IDLE;
                st_q      <= (grp_text && len_q != '0) ? S_PRE : S_ONE;
              end
            end
            M_OP: begin
              mode_q    <= M_IDLE;
              g_trunc_q <= 1'b0;
              st_q      <= S_ONE;
              if (it_q.c == CH_EQ) begin
                g_kind_q  <= OP_EQ[pop_q];
                g_more_q  <= 1'b0;
                g_start_q <= 1'b0;
              end else if (it_q.c == OP_CHAR[pop_q] && OP_DOUBLE[pop_q] != 6'd0) begin
                g_kind_q  <= OP_DOUBLE[pop_q];
                g_more_q  <= 1'b0;
                g_start_q <= 1'b0;
              end else begin
                g_kind_q  <= OP_SINGLE[pop_q];
                g_more_q  <= start_more;
                g_start_q <= 1'b1;
              end
            end
            default: st_q <= S_START;
          endcase
        end
        S_LAST: begin
          g_kind_q  <= grp_kind;
          g_trunc_q <= grp_text ? ovf_q : 1'b0;
          g_more_q  <= 1'b0;
          g_start_q <= 1'b0;
          mode_q    <= M_IDLE;
          if (mode_q == M_IDLE) st_q <= S_FIN;
          else st_q <= (grp_text && len_q != '0) ? S_PRE : S_ONE;
        end
        S_PRE: begin
          idx_q <= '0;
          st_q  <= S_TEXT;
        end
        S_TEXT: begin
          if (out_ready) begin
            out_valid_o      <= 1'b1;
            token_kind_o     <= g_kind_q;
            text_byte_o      <= rd_q;
            has_text_o       <= 1'b1;
            token_end_o      <= txt_end;
            text_truncated_o <= g_trunc_q;
            run_end_o        <= txt_end && !g_more_q;
            idx_q            <= idx_nx;
            if (txt_end) st_q <= g_start_q ? S_START : S_FIN;
          end
        end
        S_ONE: begin
          if (out_ready) begin
            out_valid_o      <= 1'b1;
            token_kind_o     <= g_kind_q;
            text_byte_o      <= 8'd0;
            has_text_o       <= 1'b0;
            token_end_o      <= 1'b1;
            text_truncated_o <= g_trunc_q;
            run_end_o        <= !g_more_q;
            st_q             <= g_start_q ? S_START : S_FIN;
          end
        end
        S_START: begin
          if (it_q.cls == CL_SYM) begin
            if (out_ready) begin
              out_valid_o      <= 1'b1;
              token_kind_o     <= it_q.sk;
              text_byte_o      <= 8'd0;
              has_text_o       <= 1'b0;
              token_end_o      <= 1'b1;
              text_truncated_o <= 1'b0;
              run_end_o        <= 1'b1;
              mode_q           <= M_IDLE;
              st_q             <= S_FIN;
            end
          end else begin
            mode_q <= start_mode;
            if (it_q.cls == CL_ALPHA || it_q.cls == CL_DIGIT) begin
              len_q <= LW'(1);
              ovf_q <= 1'b0;
              kwm_q <= kwm_new;
            end
            if (it_q.cls == CL_QUOTE) begin
              len_q <= '0;
              ovf_q <= 1'b0;
              dq_q  <= (it_q.c == CH_DQUOTE);
            end
            if (it_q.cls == CL_OP) pop_q <= it_q.op;
            st_q <= (it_q.last && start_mode != M_IDLE) ? S_LAST : S_FIN;
          end
        end
        S_FIN: begin
          if (it_q.last) begin
            mode_q <= M_IDLE;
            len_q  <= '0;
            ovf_q  <= 1'b0;
            dq_q   <= 1'b0;
            pop_q  <= 3'd0;
          end
          if (q_valid_i) begin
            it_q <= q_item_i;
            st_q <= S_EXEC;
          end else begin
            st_q <= S_WAIT;
          end
        end
        default: st_q <= S_WAIT;
      endcase
    end
  end

endmodule

### sv/source_text_lexer.sv
// Streaming lexer, one source byte per input item.
// Input channel: in_valid_i / in_stall_o with source_byte_i and
// end_of_source_i; an item is taken when valid is high and stall is low.
// A front end classifies each byte into a two-entry queue, so it keeps
// taking bytes while the back end emits, until the queue is full.
// Output channel: out_valid_o / out_stall_i with zero or more results
// per item: token kind, text byte, has_text, token_end, text_truncated, run_end.
// A byte that extends a token passes the back end states S_EXEC and
// S_FIN; a byte seen with no token open (opening one or skipped) also
// passes S_START. Ending a token adds S_ONE for a result without text,
// or S_PRE for setup and then S_TEXT for each text byte, since the text
// buffer has one registered read port. A flush at end of source passes
// S_LAST before its results.
// The output register holds while out_stall_i is high; the back end then
// waits, and the queue fills and raises in_stall_o.
// end_of_source_i flushes any open token and returns the lexer to its
// reset state. Reset clears all control state; the text buffer needs no
// clearing, as only bytes written for the current token are read.
module source_text_lexer import stl_pkg::*; #(
  parameter int TEXT_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] source_byte_i,
  input  logic       end_of_source_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] token_kind_o,
  output logic [7:0] text_byte_o,
  output logic       has_text_o,
  output logic       token_end_o,
  output logic       text_truncated_o,
  output logic       run_end_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  // Classifier and queue
  stl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  // Token engine
  stl_back #(.TEXT_DEPTH(TEXT_DEPTH)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .text_byte_o      (text_byte_o),
    .has_text_o       (has_text_o),
    .token_end_o      (token_end_o),
    .text_truncated_o (text_truncated_o),
    .run_end_o        (run_end_o)
  );

endmodule

### sv/stl_checker.sv
module stl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] token_kind_o,
  input logic [7:0] text_byte_o,
  input logic       has_text_o,
  input logic       token_end_o,
  input logic       run_end_o
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(text_byte_o) && $stable(run_end_o))
    else $error("stalled result changed");

  // A byte's run of results closes on a token boundary
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_end_o |-> token_end_o)
    else $error("run_end inside a token");

  // Results without text carry a zero byte
  a_no_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_text_o |-> text_byte_o == 8'd0 && token_end_o)
    else $error("textless result malformed");

  // Kind codes stay in range
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= 6'd42)
    else $error("token kind out of range");

endmodule

bind source_text_lexer stl_checker u_stl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .token_kind_o (token_kind_o),
  .text_byte_o  (text_byte_o),
  .has_text_o   (has_text_o),
  .token_end_o  (token_end_o),
  .run_end_o    (run_end_o)
);
